// File: sv/multichannel_adc_smoothing_unit_assert.svh
// Assertion macros shared by the block. Clock and reset are taken from the
// scope in which a macro is used: clk and rst.
`ifndef MULTICHANNEL_ADC_SMOOTHING_UNIT_ASSERT_SVH
`define MULTICHANNEL_ADC_SMOOTHING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ADCSM_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("adcsm: invariant violated");

`define ADCSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adcsm: implication violated");

`define ADCSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adcsm: next-cycle check violated");

`else

`define ADCSM_ASSERT(label, expr)

`define ADCSM_ASSERT_IMPL(label, ante, cons)

`define ADCSM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/adcsm_pkg.sv
package adcsm_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int WINDOW_LEN_DEF  = 80;
  localparam int BLOCK_LEN_DEF   = 8;
  localparam int LONG_LEN_DEF    = 6000;

  localparam int NUM_CH     = 10;
  localparam int NUM_SMOOTH = 9;
  localparam int NUM_BLOCK  = 4;

  // Channel positions in the input item.
  localparam int CH_TEMP_BATT   = 0;
  localparam int CH_RAIL_3V3    = 1;
  localparam int CH_MAINS       = 2;
  localparam int CH_BATT_I      = 3;
  localparam int CH_CHARGE_V    = 4;
  localparam int CH_TEMP_AMB    = 5;
  localparam int CH_DC_INPUT    = 6;
  localparam int CH_RAIL_24V    = 7;
  localparam int CH_RAIL_5V     = 8;
  localparam int CH_BATT_V      = 9;

  localparam int QTY_W = 5;
  typedef logic [QTY_W-1:0] qty_t;

  // Result quantity codes.
  localparam qty_t Q_CHAN_FIRST  = 5'd0;
  localparam qty_t Q_CHAN_LAST   = 5'd9;
  localparam qty_t Q_MAINS_MEAN  = 5'd10;
  localparam qty_t Q_BLOCK_FIRST = 5'd11;
  localparam qty_t Q_BLOCK_LAST  = 5'd14;
  localparam qty_t Q_LONG_MEAN   = 5'd15;
  localparam qty_t Q_READY       = 5'd16;

endpackage

// File: sv/adcsm_in_if.sv
interface adcsm_in_if #(
  parameter int SAMPLE_BITS = adcsm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] temp_battery_raw;
  logic [SAMPLE_BITS-1:0] rail_3v3_raw;
  logic [SAMPLE_BITS-1:0] mains_vacdc_raw;
  logic [SAMPLE_BITS-1:0] battery_current_raw;
  logic [SAMPLE_BITS-1:0] charge_voltage_raw;
  logic [SAMPLE_BITS-1:0] temp_ambient_raw;
  logic [SAMPLE_BITS-1:0] dc_input_raw;
  logic [SAMPLE_BITS-1:0] rail_24v_raw;
  logic [SAMPLE_BITS-1:0] rail_5v_raw;
  logic [SAMPLE_BITS-1:0] battery_voltage_raw;
  logic                   battery_active;

  modport source (
    output valid, temp_battery_raw, rail_3v3_raw, mains_vacdc_raw, battery_current_raw,
    output charge_voltage_raw, temp_ambient_raw, dc_input_raw, rail_24v_raw, rail_5v_raw,
    output battery_voltage_raw, battery_active,
    input  ready
  );

  modport sink (
    input  valid, temp_battery_raw, rail_3v3_raw, mains_vacdc_raw, battery_current_raw,
    input  charge_voltage_raw, temp_ambient_raw, dc_input_raw, rail_24v_raw, rail_5v_raw,
    input  battery_voltage_raw, battery_active,
    output ready
  );
endinterface

// File: sv/adcsm_out_if.sv
interface adcsm_out_if #(
  parameter int SAMPLE_BITS = adcsm_pkg::SAMPLE_BITS_DEF
);
  import adcsm_pkg::*;

  logic                   valid;
  logic                   ready;
  qty_t                   quantity;
  logic [SAMPLE_BITS-1:0] value;
  logic                   last;

  modport source (output valid, quantity, value, last, input ready);
  modport sink (input valid, quantity, value, last, output ready);
endinterface

// File: sv/multichannel_adc_smoothing_unit.sv
// Flow: an accepted tick is registered in stage 1, stage 2 and stage 3 in turn, and
// stage 3 offers its results. Throughput: one result per cycle on the output while
// the sink is ready; a tick gives 11 to 17 results. The output serializer sets the
// sustained rate, with up to two more ticks waiting in the pipeline ahead of it.
// Reset (synchronous, rst high) clears all filter state; window entries read as zero
// through per-entry valid flags until rewritten, and an item is taken right after reset.
`include "multichannel_adc_smoothing_unit_assert.svh"

module multichannel_adc_smoothing_unit #(
  parameter int SAMPLE_BITS = adcsm_pkg::SAMPLE_BITS_DEF,
  parameter int WINDOW_LEN  = adcsm_pkg::WINDOW_LEN_DEF,
  parameter int BLOCK_LEN   = adcsm_pkg::BLOCK_LEN_DEF,
  parameter int LONG_LEN    = adcsm_pkg::LONG_LEN_DEF
) (
  input logic          clk,
  input logic          rst,
  adcsm_in_if.sink     samples,
  adcsm_out_if.source  results
);
  import adcsm_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int SMAX = (1 << SB) - 1;

  // Window mean: divide by WINDOW_LEN through a rounded-up reciprocal.
  localparam int WSUM_W  = $clog2(WINDOW_LEN * SMAX + 1);
  localparam int WIDX_W  = $clog2(WINDOW_LEN);
  localparam int WDIV_SH = WSUM_W + $clog2(WINDOW_LEN);
  localparam logic [WSUM_W:0] WDIV_MUL = (WSUM_W + 1)'(
      ((64'd1 << WDIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [WSUM_W-1:0] WSUM_MAX = WSUM_W'(WINDOW_LEN * SMAX);

  localparam int BSUM_W  = $clog2(BLOCK_LEN * SMAX + 1);
  localparam int BCNT_W  = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int BDIV_SH = BSUM_W + $clog2(BLOCK_LEN);
  localparam logic [BSUM_W:0] BDIV_MUL = (BSUM_W + 1)'(
      ((64'd1 << BDIV_SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

  localparam int LACC_W  = $clog2(LONG_LEN * SMAX + 1);
  localparam int LCNT_W  = (LONG_LEN > 1) ? $clog2(LONG_LEN) : 1;
  localparam int LDIV_SH = LACC_W + $clog2(LONG_LEN);
  localparam logic [LACC_W:0] LDIV_MUL = (LACC_W + 1)'(
      ((64'd1 << LDIV_SH) + 64'(LONG_LEN) - 64'd1) / 64'(LONG_LEN));

  localparam int RES_N     = 16;
  localparam int RES_MAINS = int'(Q_MAINS_MEAN);
  localparam int RES_BLOCK = int'(Q_BLOCK_FIRST);
  localparam int RES_LONG  = int'(Q_LONG_MEAN);

  localparam int BLK_SRC [NUM_BLOCK] = '{CH_DC_INPUT, CH_BATT_V, CH_CHARGE_V, CH_BATT_I};

  typedef logic [SB-1:0] smp_t;

  // Handshake and stage control.
  logic in_fire, out_fire;
  logic s1_valid, s2_valid, s3_valid;
  logic s1_adv, s2_adv, s2_free, s3_free;

  // Stage 1: captured item and the window entry it replaces.
  smp_t              in_smp [NUM_CH];
  smp_t              s1_smp [NUM_CH];
  logic              s1_act;
  logic [WIDX_W-1:0] s1_idx;
  logic              s1_old_vld;

  // Filter state.
  smp_t              prev [NUM_SMOOTH];
  smp_t              sm_smp [NUM_SMOOTH];
  logic [WIDX_W-1:0] win_idx;
  logic [WINDOW_LEN-1:0] win_vld;
  logic [WSUM_W-1:0] msum, msum_next;
  logic [BSUM_W-1:0] bsum [NUM_BLOCK];
  logic [BSUM_W-1:0] bsum_new [NUM_BLOCK];
  logic [BCNT_W-1:0] blk_cnt;
  logic [LCNT_W-1:0] lng_cnt;
  logic [LACC_W-1:0] lacc, lacc_new;
  logic              blk_done, lng_done;

  smp_t win_rdata, win_old;
  smp_t chan_val [NUM_CH];

  // Stage 2: sums waiting for their reciprocal multiplies.
  smp_t              s2_chan [NUM_CH];
  logic [WSUM_W-1:0] s2_msum;
  logic [BSUM_W-1:0] s2_bsum [NUM_BLOCK];
  logic [LACC_W-1:0] s2_lacc;
  logic              s2_blk, s2_lng, s2_act;

  logic [2*WSUM_W:0] wprod;
  logic [2*BSUM_W:0] bprod [NUM_BLOCK];
  logic [2*LACC_W:0] lprod;

  // Stage 3: finished result set, read out one result per cycle while ready is high.
  smp_t res_in [RES_N];
  smp_t s3_res [RES_N];
  logic s3_blk, s3_lng, s3_act;
  qty_t pos, pos_next;
  logic pos_last;

  assign in_smp[CH_TEMP_BATT] = samples.temp_battery_raw;
  assign in_smp[CH_RAIL_3V3]  = samples.rail_3v3_raw;
  assign in_smp[CH_MAINS]     = samples.mains_vacdc_raw;
  assign in_smp[CH_BATT_I]    = samples.battery_current_raw;
  assign in_smp[CH_CHARGE_V]  = samples.charge_voltage_raw;
  assign in_smp[CH_TEMP_AMB]  = samples.temp_ambient_raw;
  assign in_smp[CH_DC_INPUT]  = samples.dc_input_raw;
  assign in_smp[CH_RAIL_24V]  = samples.rail_24v_raw;
  assign in_smp[CH_RAIL_5V]   = samples.rail_5v_raw;
  assign in_smp[CH_BATT_V]    = samples.battery_voltage_raw;

  assign out_fire = results.valid && results.ready;
  assign s3_free  = !s3_valid || (out_fire && pos_last);
  assign s2_adv   = s2_valid && s3_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_adv   = s1_valid && s2_free;
  assign samples.ready = !s1_valid || s2_free;
  assign in_fire  = samples.valid && samples.ready;

  // The window entry is read when the item is accepted and written back when it
  // leaves stage 1. Consecutive items touch consecutive entries, so a read never
  // meets a write to the same entry in one cycle.
  adcsm_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx),
    .wdata (s1_smp[CH_MAINS]),
    .re    (in_fire),
    .raddr (win_idx),
    .rdata (win_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      pos      <= Q_CHAN_FIRST;
      win_idx  <= '0;
      win_vld  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        win_idx  <= (win_idx == WIDX_W'(WINDOW_LEN - 1)) ? '0 : win_idx + WIDX_W'(1);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid        <= 1'b1;
        win_vld[s1_idx] <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        s3_valid <= 1'b1;
        pos      <= Q_CHAN_FIRST;
      end else if (out_fire) begin
        if (pos_last) begin
          s3_valid <= 1'b0;
        end else begin
          pos <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_smp     <= in_smp;
      s1_act     <= samples.battery_active;
      s1_idx     <= win_idx;
      s1_old_vld <= win_vld[win_idx];
    end
  end

  // Stage 1 arithmetic.
  assign win_old   = s1_old_vld ? win_rdata : '0;
  assign msum_next = WSUM_W'({1'b0, msum} + (WSUM_W + 1)'(s1_smp[CH_MAINS])
                             - (WSUM_W + 1)'(win_old));
  assign blk_done  = (blk_cnt == BCNT_W'(BLOCK_LEN - 1));
  assign lng_done  = s1_act && (lng_cnt == LCNT_W'(LONG_LEN - 1));
  assign lacc_new  = lacc + LACC_W'(s1_smp[CH_BATT_I]);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    if (c == CH_MAINS) begin : g_raw
      assign chan_val[c] = s1_smp[c];
    end else begin : g_smooth
      localparam int Slot = (c < CH_MAINS) ? c : c - 1;
      logic [SB+1:0] tri_sum;
      assign tri_sum = (SB + 2)'({prev[Slot], 1'b0}) + (SB + 2)'(prev[Slot])
                       + (SB + 2)'(s1_smp[c]);
      assign chan_val[c]  = tri_sum[SB+1:2];
      assign sm_smp[Slot] = s1_smp[c];
    end
  end

  for (genvar i = 0; i < NUM_BLOCK; i++) begin : g_blk
    assign bsum_new[i] = bsum[i] + BSUM_W'(s1_smp[BLK_SRC[i]]);
    assign bprod[i] = (2 * BSUM_W + 1)'(s2_bsum[i]) * (2 * BSUM_W + 1)'(BDIV_MUL);
    assign res_in[RES_BLOCK + i] = bprod[i][BDIV_SH +: SB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev    <= '{default: '0};
      msum    <= '0;
      bsum    <= '{default: '0};
      blk_cnt <= '0;
      lng_cnt <= '0;
      lacc    <= '0;
    end else if (s1_adv) begin
      prev <= sm_smp;
      msum <= msum_next;
      if (blk_done) begin
        blk_cnt <= '0;
        bsum    <= '{default: '0};
      end else begin
        blk_cnt <= blk_cnt + BCNT_W'(1);
        bsum    <= bsum_new;
      end
      if (s1_act) begin
        if (lng_done) begin
          lng_cnt <= '0;
          lacc    <= '0;
        end else begin
          lng_cnt <= lng_cnt + LCNT_W'(1);
          lacc    <= lacc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_chan <= chan_val;
      s2_msum <= msum_next;
      s2_bsum <= bsum_new;
      s2_lacc <= lacc_new;
      s2_blk  <= blk_done;
      s2_lng  <= lng_done;
      s2_act  <= s1_act;
    end
  end

  // Stage 2: each mean is the high part of sum times reciprocal.
  assign wprod = (2 * WSUM_W + 1)'(s2_msum) * (2 * WSUM_W + 1)'(WDIV_MUL);
  assign lprod = (2 * LACC_W + 1)'(s2_lacc) * (2 * LACC_W + 1)'(LDIV_MUL);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_res
    assign res_in[c] = s2_chan[c];
  end
  assign res_in[RES_MAINS] = wprod[WDIV_SH +: SB];
  assign res_in[RES_LONG]  = lprod[LDIV_SH +: SB];

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_res <= res_in;
      s3_blk <= s2_blk;
      s3_lng <= s2_lng;
      s3_act <= s2_act;
    end
  end

  // Walk the quantities of the held tick, skipping those it does not report.
  always_comb begin
    pos_next = pos;
    pos_last = 1'b0;
    case (pos) inside
      [Q_CHAN_FIRST:Q_CHAN_LAST]: pos_next = pos + qty_t'(1);
      Q_BLOCK_LAST, Q_MAINS_MEAN: begin
        if (pos == Q_MAINS_MEAN && s3_blk) begin
          pos_next = Q_BLOCK_FIRST;
        end else if (s3_lng) begin
          pos_next = Q_LONG_MEAN;
        end else if (!s3_act) begin
          pos_next = Q_READY;
        end else begin
          pos_last = 1'b1;
        end
      end
      [Q_BLOCK_FIRST:Q_BLOCK_LAST]: pos_next = pos + qty_t'(1);
      Q_LONG_MEAN: pos_next = Q_READY;
      default: pos_last = 1'b1;
    endcase
  end

  assign results.valid    = s3_valid;
  assign results.quantity = pos;
  assign results.value    = (pos == Q_READY) ? SB'(s3_lng) : s3_res[pos[3:0]];
  assign results.last     = pos_last;

  `ADCSM_ASSERT(a_window_no_clash, !(in_fire && s1_adv && (win_idx == s1_idx)))
  `ADCSM_ASSERT(a_window_sum_range, msum <= WSUM_MAX)
  `ADCSM_ASSERT(a_block_count_range, blk_cnt <= BCNT_W'(BLOCK_LEN - 1))
  `ADCSM_ASSERT_NEXT(a_set_starts, s2_adv, s3_valid && (pos == Q_CHAN_FIRST))
  `ADCSM_ASSERT_NEXT(a_long_idle_holds, s1_adv && !s1_act, $stable(lacc) && $stable(lng_cnt))

endmodule

// File: sv/adcsm_ram.sv
module adcsm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: tb/multichannel_adc_smoothing_unit_tb.sv
`timescale 1ns / 1ps

module multichannel_adc_smoothing_unit_tb;
  import adcsm_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int WINDOW_LEN  = WINDOW_LEN_DEF;
  localparam int BLOCK_LEN   = BLOCK_LEN_DEF;
  localparam int LONG_LEN    = LONG_LEN_DEF;

  localparam int TICKS_PER_PHASE = 86;
  localparam int NUM_PHASES      = 4;
  localparam int STALL_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int MAX_REPORTS     = 10;
  localparam int NO_EXP          = -1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] raw_vec_t;

  typedef struct packed {
    raw_vec_t raw;
    logic     active;
  } tick_t;

  typedef struct packed {
    qty_t    quantity;
    sample_t value;
    logic    last;
  } result_t;

  typedef struct packed {
    sample_t level;
    logic    alternate;
    logic    active;
    int      exp_smooth;
    int      exp_mean;
  } dir_row_t;

  localparam int BLOCK_SRC [NUM_BLOCK] = '{CH_DC_INPUT, CH_BATT_V, CH_CHARGE_V, CH_BATT_I};

  // Rows with alternate set put the inverted level on odd channels. The first eight
  // rows start from reset and carry the smoothed and window mean values worked out by
  // hand; the rest are checked by the filter model alone.
  localparam dir_row_t DIRECTED_ROWS [16] = '{
    '{10'd1023,  1'b0, 1'b0, 255,    12},
    '{10'd1023,  1'b0, 1'b0, 1023,   25},
    '{10'd0,     1'b0, 1'b1, 767,    25},
    '{10'd0,     1'b0, 1'b1, 0,      25},
    '{10'd1023,  1'b0, 1'b1, 255,    38},
    '{10'd512,   1'b0, 1'b0, 895,    44},
    '{10'd1,     1'b0, 1'b1, 384,    44},
    '{10'd1023,  1'b0, 1'b1, 256,    57},
    '{10'h2AA,   1'b1, 1'b1, NO_EXP, NO_EXP},
    '{10'h155,   1'b1, 1'b0, NO_EXP, NO_EXP},
    '{10'h000,   1'b1, 1'b1, NO_EXP, NO_EXP},
    '{10'h3FF,   1'b1, 1'b1, NO_EXP, NO_EXP},
    '{10'h0F0,   1'b1, 1'b0, NO_EXP, NO_EXP},
    '{10'h30F,   1'b1, 1'b1, NO_EXP, NO_EXP},
    '{10'h001,   1'b1, 1'b0, NO_EXP, NO_EXP},
    '{10'h200,   1'b1, 1'b1, NO_EXP, NO_EXP}
  };

  localparam int SRC_IDLE_PCT [NUM_PHASES]  = '{0, 63, 0, 7};
  localparam int SINK_STALL_PCT [NUM_PHASES] = '{0, 0, 63, 7};

  logic clk = 1'b0;
  logic rst;

  adcsm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  adcsm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

  multichannel_adc_smoothing_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WINDOW_LEN (WINDOW_LEN),
    .BLOCK_LEN  (BLOCK_LEN),
    .LONG_LEN   (LONG_LEN)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch),
    .results(result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter model state.
  sample_t     prev_raw [NUM_SMOOTH];
  sample_t     mains_hist [WINDOW_LEN];
  logic [6:0]  mains_pos;
  logic [16:0] mains_total;
  logic [14:0] blk_total [NUM_BLOCK];
  logic [5:0]  blk_ticks;
  logic [12:0] long_ticks;
  logic [22:0] long_total;

  result_t tick_results [$];
  result_t pending_results [$];

  int   mismatch_count = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   quiet_cycles = 0;
  logic batt_active = 1'b1;

  function automatic void clear_filter_model();
    foreach (prev_raw[i]) prev_raw[i] = '0;
    foreach (mains_hist[i]) mains_hist[i] = '0;
    foreach (blk_total[i]) blk_total[i] = '0;
    mains_pos   = '0;
    mains_total = '0;
    blk_ticks   = '0;
    long_ticks  = '0;
    long_total  = '0;
  endfunction

  function automatic void add_result(input qty_t quantity, input sample_t value);
    tick_results.push_back('{quantity: quantity, value: value, last: 1'b0});
  endfunction

  // Works out every result that one tick causes, in output order, into tick_results.
  function automatic void filter_tick(input tick_t t);
    int          slot;
    logic [11:0] weighted;
    tick_results.delete();
    slot = 0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (ch == CH_MAINS) begin
        add_result(qty_t'(ch), t.raw[ch]);
      end else begin
        weighted = 12'(prev_raw[slot]) * 12'd3 + 12'(t.raw[ch]);
        prev_raw[slot] = t.raw[ch];
        slot++;
        add_result(qty_t'(ch), weighted[11:2]);
      end
    end

    mains_total = mains_total - 17'(mains_hist[mains_pos]) + 17'(t.raw[CH_MAINS]);
    mains_hist[mains_pos] = t.raw[CH_MAINS];
    mains_pos = (mains_pos == WINDOW_LEN - 1) ? '0 : mains_pos + 7'd1;
    add_result(Q_MAINS_MEAN, sample_t'(mains_total / WINDOW_LEN));

    for (int b = 0; b < NUM_BLOCK; b++) blk_total[b] += 15'(t.raw[BLOCK_SRC[b]]);
    blk_ticks++;
    if (blk_ticks >= BLOCK_LEN) begin
      for (int b = 0; b < NUM_BLOCK; b++) begin
        add_result(Q_BLOCK_FIRST + qty_t'(b), sample_t'(blk_total[b] / BLOCK_LEN));
        blk_total[b] = '0;
      end
      blk_ticks = '0;
    end

    if (t.active) begin
      long_ticks++;
      long_total += 23'(t.raw[CH_BATT_I]);
      if (long_ticks >= LONG_LEN) begin
        add_result(Q_LONG_MEAN, sample_t'(long_total / LONG_LEN));
        add_result(Q_READY, sample_t'(1));
        long_total = '0;
        long_ticks = '0;
      end
    end else begin
      add_result(Q_READY, sample_t'(0));
    end

    tick_results[tick_results.size() - 1].last = 1'b1;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: pick_sample = '0;
      1: pick_sample = '1;
      default: pick_sample = sample_t'($urandom);
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    for (int ch = 0; ch < NUM_CH; ch++) t.raw[ch] = pick_sample();
    // The battery flag comes in runs of ticks, as it does on a real charger.
    if (batt_active && $urandom_range(99) < 6) batt_active = 1'b0;
    else if (!batt_active && $urandom_range(99) < 25) batt_active = 1'b1;
    t.active = batt_active;
    random_tick = t;
  endfunction

  function automatic tick_t directed_tick(input dir_row_t row);
    tick_t t;
    for (int ch = 0; ch < NUM_CH; ch++)
      t.raw[ch] = (row.alternate && ch % 2 == 1) ? ~row.level : row.level;
    t.active = row.active;
    directed_tick = t;
  endfunction

  task automatic send_tick(input tick_t t, input int exp_smooth, input int exp_mean);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid               <= 1'b1;
    sample_ch.temp_battery_raw    <= t.raw[CH_TEMP_BATT];
    sample_ch.rail_3v3_raw        <= t.raw[CH_RAIL_3V3];
    sample_ch.mains_vacdc_raw     <= t.raw[CH_MAINS];
    sample_ch.battery_current_raw <= t.raw[CH_BATT_I];
    sample_ch.charge_voltage_raw  <= t.raw[CH_CHARGE_V];
    sample_ch.temp_ambient_raw    <= t.raw[CH_TEMP_AMB];
    sample_ch.dc_input_raw        <= t.raw[CH_DC_INPUT];
    sample_ch.rail_24v_raw        <= t.raw[CH_RAIL_24V];
    sample_ch.rail_5v_raw         <= t.raw[CH_RAIL_5V];
    sample_ch.battery_voltage_raw <= t.raw[CH_BATT_V];
    sample_ch.battery_active      <= t.active;
    @(posedge clk);
    while (sample_ch.ready !== 1'b1) @(posedge clk);

    filter_tick(t);
    foreach (tick_results[i]) begin
      if (exp_smooth != NO_EXP && tick_results[i].quantity <= Q_CHAN_LAST &&
          tick_results[i].quantity != qty_t'(CH_MAINS))
        tick_results[i].value = sample_t'(exp_smooth);
      if (exp_mean != NO_EXP && tick_results[i].quantity == Q_MAINS_MEAN)
        tick_results[i].value = sample_t'(exp_mean);
      pending_results.push_back(tick_results[i]);
    end
  endtask

  // Holds the input back until every expected result has come out.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t seen);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%s (quantity/value/last): expected %0d/%0d/%0b, actual %0d/%0d/%0b",
               what, want.quantity, want.value, want.last,
               seen.quantity, seen.value, seen.last);
  endfunction

  always @(posedge clk) begin : result_monitor
    result_t seen;
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        seen = '{quantity: result_ch.quantity, value: result_ch.value, last: result_ch.last};
        if (pending_results.size() == 0) begin
          note_mismatch("Result with none expected", '0, seen);
        end else begin
          want = pending_results.pop_front();
          if (seen.quantity !== want.quantity || seen.value !== want.value ||
              seen.last !== want.last)
            note_mismatch("Result mismatch", want, seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst                           <= 1'b1;
    sample_ch.valid               <= 1'b0;
    sample_ch.temp_battery_raw    <= '0;
    sample_ch.rail_3v3_raw        <= '0;
    sample_ch.mains_vacdc_raw     <= '0;
    sample_ch.battery_current_raw <= '0;
    sample_ch.charge_voltage_raw  <= '0;
    sample_ch.temp_ambient_raw    <= '0;
    sample_ch.dc_input_raw        <= '0;
    sample_ch.rail_24v_raw        <= '0;
    sample_ch.rail_5v_raw         <= '0;
    sample_ch.battery_voltage_raw <= '0;
    sample_ch.battery_active      <= 1'b0;
    clear_filter_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_tick(directed_tick(DIRECTED_ROWS[i]), DIRECTED_ROWS[i].exp_smooth,
                DIRECTED_ROWS[i].exp_mean);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      src_idle_pct   = SRC_IDLE_PCT[phase];
      sink_stall_pct = SINK_STALL_PCT[phase];
      for (int n = 0; n < TICKS_PER_PHASE; n++) send_tick(random_tick(), NO_EXP, NO_EXP);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: multichannel_adc_smoothing_unit.f
+incdir+sv
sv/adcsm_pkg.sv
sv/adcsm_in_if.sv
sv/adcsm_out_if.sv
sv/adcsm_ram.sv
sv/multichannel_adc_smoothing_unit.sv
tb/multichannel_adc_smoothing_unit_tb.sv
